[rtl/rcwp_pkg.sv]
// Shared constants for the raycast wall column projector.
// Holds register reset values, register indexes and default parameters.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcwp_pkg;

	// Default parameter values for the top level.
	localparam int RAY_COUNT_DEFAULT   = 128;
	localparam int SHADE_STEPS_DEFAULT = 4;

	// Field widths.
	localparam int ROWS_W    = 10;
	localparam int SCALE_W   = 24;
	localparam int DIST_W    = 16;
	localparam int COLOUR_W  = 32;
	localparam int RAY_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// Register reset values.
	localparam logic [ROWS_W-1:0]  ROWS_RESET  = 10'd480;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd106906;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_SCALE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHADE_0     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHADE_1     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHADE_2     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHADE_3     = 3'd5;

endpackage

`default_nettype wire

[rtl/raycast_wall_column_projector_core.sv]
// Raycast wall column projector: per-ray wall rows, shading and nearest-ray tracking.
// Depends on rcwp_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// One request on the input channel carries one ray's wall distance (unsigned
// Q8.8) and a flag for the last ray of the frame. Each request yields exactly
// one result with the wall's top and bottom rows, the band colour and, on the
// last ray, the index and top row of the frame's closest ray.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no request is in flight.
// Sequence: the request is taken in the idle state, the serial restoring
// divider (one quotient bit per cycle, wall_scale over wall_distance) runs in
// the divide state, and the result is formed in the finish state. The block
// takes no new request until it is through with the last one; in_stall is
// high from the accepting edge until the result has been formed.
// The result sits in an output register, so the block accepts the next
// request while a result is stalled; it waits in its final cycle only when
// the previous result is still held.
// Reset clears the registers to their defaults, the frame tracking and the
// output valid flag; no request is in flight afterwards.
module raycast_wall_column_projector_core #(
	parameter int RAY_COUNT   = rcwp_pkg::RAY_COUNT_DEFAULT,
	parameter int SHADE_STEPS = rcwp_pkg::SHADE_STEPS_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration write channel.
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rcwp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rcwp_pkg::CFG_DAT_W-1:0]  cfg_data,
	// Ray input channel.
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [rcwp_pkg::DIST_W-1:0]     wall_distance,
	input  wire logic                            last_ray,
	// Result channel.
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [rcwp_pkg::ROWS_W-1:0]          top_row,
	output logic [rcwp_pkg::ROWS_W-1:0]          bottom_row,
	output logic [rcwp_pkg::COLOUR_W-1:0]        wall_colour,
	output logic [rcwp_pkg::RAY_W-1:0]           nearest_ray,
	output logic [rcwp_pkg::ROWS_W-1:0]          nearest_top_row,
	output logic                                 frame_done
);

	import rcwp_pkg::*;

	// Last ray index that the position counter may reach.
	localparam int RAY_LAST_INT = (RAY_COUNT > 256) ? 255 : RAY_COUNT - 1;
	localparam logic [RAY_W-1:0] RAY_LIMIT = RAY_LAST_INT[RAY_W-1:0];
	// Number of shading bands, held to the range one to four.
	localparam int SHADE_INT = (SHADE_STEPS < 1) ? 1 : ((SHADE_STEPS > 4) ? 4 : SHADE_STEPS);
	localparam logic [2:0] SHADE_LEVELS = SHADE_INT[2:0];
	localparam logic [1:0] SHADE_MAX    = 2'(SHADE_INT - 1);
	// Divider iteration count.
	localparam int DIV_STEPS = SCALE_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
	localparam int PROD_W = DIST_W + 2;
	localparam int HALF_W = ROWS_W - 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t                  state_q;

	// Configuration registers.
	logic [ROWS_W-1:0]       rows_q;
	logic [SCALE_W-1:0]      scale_q;
	logic [COLOUR_W-1:0]     shade_q [4];

	// Current request and divider state.
	logic [DIST_W-1:0]       dist_q;
	logic                    last_q;
	logic [SCALE_W-1:0]      quo_q;
	logic [DIST_W-1:0]       rem_q;
	logic [CNT_W-1:0]        count_q;

	// Frame tracking.
	logic [RAY_W-1:0]        ray_pos_q;
	logic [DIST_W-1:0]       best_dist_q;
	logic [RAY_W-1:0]        best_ray_q;
	logic [ROWS_W-1:0]       best_top_q;

	// Output register.
	logic                    out_valid_q;
	logic [ROWS_W-1:0]       top_q;
	logic [ROWS_W-1:0]       bottom_q;
	logic [COLOUR_W-1:0]     colour_q;
	logic [RAY_W-1:0]        near_ray_q;
	logic [ROWS_W-1:0]       near_top_q;
	logic                    done_q;

	// Combinational values.
	logic [DIST_W:0]         trial;
	logic                    fits;
	logic [DIST_W-1:0]       rem_next;
	logic [HALF_W-1:0]       half;
	logic [ROWS_W-1:0]       top_calc;
	logic [ROWS_W-1:0]       bottom_calc;
	logic [PROD_W-1:0]       band_prod;
	logic [7:0]              band_coarse;
	logic [1:0]              band_raw;
	logic [1:0]              band;
	logic                    take_best;
	logic [RAY_W-1:0]        new_best_ray;
	logic [ROWS_W-1:0]       new_best_top;
	logic                    out_free;

	assign cfg_ready       = 1'b1;
	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign top_row         = top_q;
	assign bottom_row      = bottom_q;
	assign wall_colour     = colour_q;
	assign nearest_ray     = near_ray_q;
	assign nearest_top_row = near_top_q;
	assign frame_done      = done_q;
	assign out_free        = !out_valid_q || !out_stall;

	// One restoring divide step: shift in the next dividend bit and try the subtract.
	always_comb begin
		trial    = {rem_q, quo_q[SCALE_W-1]};
		fits     = (trial >= {1'b0, dist_q});
		rem_next = fits ? DIST_W'(trial - {1'b0, dist_q}) : trial[DIST_W-1:0];
	end

	// Wall rows from the finished quotient, clamped at row zero.
	always_comb begin
		half = rows_q[ROWS_W-1:1];
		if (dist_q == '0 || (|quo_q[SCALE_W-1:HALF_W]) || quo_q[HALF_W-1:0] >= half) begin
			top_calc = '0;
		end else begin
			top_calc = {1'b0, half - quo_q[HALF_W-1:0]};
		end
		bottom_calc = rows_q - top_calc;
	end

	// Shading band: the product over 3072 is the product over 1024, then over three.
	always_comb begin
		band_prod   = PROD_W'(SHADE_LEVELS) * PROD_W'(dist_q);
		band_coarse = band_prod[PROD_W-1:10];
		if (band_coarse < 8'd3) begin
			band_raw = 2'd0;
		end else if (band_coarse < 8'd6) begin
			band_raw = 2'd1;
		end else if (band_coarse < 8'd9) begin
			band_raw = 2'd2;
		end else begin
			band_raw = 2'd3;
		end
		band = (band_raw > SHADE_MAX) ? SHADE_MAX : band_raw;
	end

	// The first ray of a frame always wins; later rays must be strictly closer.
	always_comb begin
		take_best    = (ray_pos_q == '0) || (dist_q < best_dist_q);
		new_best_ray = take_best ? ray_pos_q : best_ray_q;
		new_best_top = take_best ? top_calc : best_top_q;
	end

	// Sequencer, configuration, tracking and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= ROWS_RESET;
			scale_q     <= SCALE_RESET;
			shade_q[0]  <= '0;
			shade_q[1]  <= '0;
			shade_q[2]  <= '0;
			shade_q[3]  <= '0;
			ray_pos_q   <= '0;
			best_dist_q <= '1;
			best_ray_q  <= '0;
			best_top_q  <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			// Register writes; unknown indexes are dropped.
			if (cfg_valid) begin
				case (cfg_index)
					REG_SCREEN_ROWS: rows_q     <= cfg_data[ROWS_W-1:0];
					REG_WALL_SCALE:  scale_q    <= cfg_data[SCALE_W-1:0];
					REG_SHADE_0:     shade_q[0] <= cfg_data;
					REG_SHADE_1:     shade_q[1] <= cfg_data;
					REG_SHADE_2:     shade_q[2] <= cfg_data;
					REG_SHADE_3:     shade_q[3] <= cfg_data;
					default: ;
				endcase
			end

			// The result flag is set when a column is formed and cleared once it is taken.
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						dist_q  <= wall_distance;
						last_q  <= last_ray;
						quo_q   <= scale_q;
						rem_q   <= '0;
						count_q <= '0;
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					quo_q   <= {quo_q[SCALE_W-2:0], fits};
					rem_q   <= rem_next;
					count_q <= count_q + 1'b1;
					if (count_q == CNT_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						top_q       <= top_calc;
						bottom_q    <= bottom_calc;
						colour_q    <= shade_q[band];
						if (last_q) begin
							near_ray_q  <= new_best_ray;
							near_top_q  <= new_best_top;
							done_q      <= 1'b1;
							ray_pos_q   <= '0;
							best_dist_q <= '1;
							best_ray_q  <= '0;
							best_top_q  <= '0;
						end else begin
							near_ray_q <= '0;
							near_top_q <= '0;
							done_q     <= 1'b0;
							if (take_best) begin
								best_dist_q <= dist_q;
							end
							best_ray_q <= new_best_ray;
							best_top_q <= new_best_top;
							if (ray_pos_q < RAY_LIMIT) begin
								ray_pos_q <= ray_pos_q + 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// A taken request keeps the input stalled while the divider runs.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a request");

	// The divider never runs past its last quotient bit.
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (count_q <= CNT_LAST))
		else $error("divider step count out of range");

	// Top and bottom rows always add up to the screen height.
	a_rows_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ROWS_W'(top_row + bottom_row) == rows_q))
		else $error("top and bottom rows do not span the screen");

	// Nearest-ray fields are zero except on the frame's last result.
	a_nearest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_done) |-> (nearest_ray == '0 && nearest_top_row == '0))
		else $error("nearest-ray fields set outside frame end");

	// A new result is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(top_q) && $stable(colour_q))
		else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

[bench/raycast_wall_column_projector_core_tb.sv]
// Self-checking bench for raycast_wall_column_projector_core: rays go in, and every column
// result is checked against a column predictor held in a small scoreboard class.
// Depends on rcwp_pkg and the core RTL only.
`timescale 1ns / 1ps

// The band index is floor(steps * raw_distance / 3072), i.e. the bands split twelve distance units evenly.
localparam int unsigned BAND_DIVISOR = 3072;

typedef struct packed {
	logic [rcwp_pkg::ROWS_W-1:0]   top_row;
	logic [rcwp_pkg::ROWS_W-1:0]   bottom_row;
	logic [rcwp_pkg::COLOUR_W-1:0] wall_colour;
	logic [rcwp_pkg::RAY_W-1:0]    nearest_ray;
	logic [rcwp_pkg::ROWS_W-1:0]   nearest_top_row;
	logic                          frame_done;
} column_result_t;

class column_scoreboard;
	// Copies of the configuration registers.
	logic [rcwp_pkg::ROWS_W-1:0]   screen_rows;
	logic [rcwp_pkg::SCALE_W-1:0]  wall_scale;
	logic [rcwp_pkg::COLOUR_W-1:0] shade_colour [4];
	// Frame tracking of the closest ray.
	logic [rcwp_pkg::RAY_W-1:0]    ray_position;
	logic [rcwp_pkg::DIST_W-1:0]   best_distance;
	logic [rcwp_pkg::RAY_W-1:0]    best_ray;
	logic [rcwp_pkg::ROWS_W-1:0]   best_top;
	column_result_t                pending_columns [$];
	int                            failures;
	int                            checked;
	int                            frames;

	function new();
		screen_rows = rcwp_pkg::ROWS_RESET;
		wall_scale = rcwp_pkg::SCALE_RESET;
		foreach (shade_colour[i]) shade_colour[i] = '0;
		clear_tracking();
		failures = 0;
		checked = 0;
		frames = 0;
	endfunction

	function void clear_tracking();
		ray_position = '0;
		best_distance = '1;
		best_ray = '0;
		best_top = '0;
	endfunction

	// Register writes keep only the register's width; unknown indexes change nothing.
	function void set_register(logic [rcwp_pkg::CFG_IDX_W-1:0] index,
			logic [rcwp_pkg::CFG_DAT_W-1:0] data);
		case (index)
			rcwp_pkg::REG_SCREEN_ROWS: screen_rows = data[rcwp_pkg::ROWS_W-1:0];
			rcwp_pkg::REG_WALL_SCALE:  wall_scale = data[rcwp_pkg::SCALE_W-1:0];
			rcwp_pkg::REG_SHADE_0:     shade_colour[0] = data;
			rcwp_pkg::REG_SHADE_1:     shade_colour[1] = data;
			rcwp_pkg::REG_SHADE_2:     shade_colour[2] = data;
			rcwp_pkg::REG_SHADE_3:     shade_colour[3] = data;
			default: ;
		endcase
	endfunction

	// Top row is half height minus the projected half wall, clamped at row 0.
	function logic [rcwp_pkg::ROWS_W-1:0] wall_top(logic [rcwp_pkg::DIST_W-1:0] distance);
		logic [rcwp_pkg::ROWS_W-1:0]  half;
		logic [rcwp_pkg::SCALE_W-1:0] quot;
		half = screen_rows >> 1;
		if (distance == '0) return '0;
		quot = wall_scale / distance;
		if (quot >= half) return '0;
		return half - quot[rcwp_pkg::ROWS_W-1:0];
	endfunction

	// Distance band, clamped to the last gradient entry.
	function int unsigned shade_band(logic [rcwp_pkg::DIST_W-1:0] distance);
		int unsigned steps;
		int unsigned band;
		steps = rcwp_pkg::SHADE_STEPS_DEFAULT;
		if (steps < 1) steps = 1;
		if (steps > 4) steps = 4;
		band = (steps * 32'(distance)) / BAND_DIVISOR;
		if (band >= steps) band = steps - 1;
		return band;
	endfunction

	// Works out the column for one accepted request and advances the frame tracking.
	function void note_request(logic [rcwp_pkg::DIST_W-1:0] distance, logic last);
		column_result_t                column;
		logic [rcwp_pkg::ROWS_W-1:0]   top;
		int unsigned                   limit;
		top = wall_top(distance);
		limit = rcwp_pkg::RAY_COUNT_DEFAULT - 1;
		if (limit > 255) limit = 255;
		if (ray_position == '0 || distance < best_distance) begin
			best_distance = distance;
			best_ray = ray_position;
			best_top = top;
		end
		column.top_row = top;
		column.bottom_row = screen_rows - top;
		column.wall_colour = shade_colour[shade_band(distance)];
		column.nearest_ray = '0;
		column.nearest_top_row = '0;
		column.frame_done = 1'b0;
		if (last) begin
			column.nearest_ray = best_ray;
			column.nearest_top_row = best_top;
			column.frame_done = 1'b1;
			frames++;
			clear_tracking();
		end else if (ray_position < limit) begin
			ray_position = ray_position + 1'b1;
		end
		pending_columns.push_back(column);
	endfunction

	// Compares one delivered column with the oldest outstanding prediction.
	function void check_result(column_result_t got);
		column_result_t want;
		if (pending_columns.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected column: top %0d bottom %0d colour %h near %0d/%0d done %0d",
					got.top_row, got.bottom_row, got.wall_colour, got.nearest_ray,
					got.nearest_top_row, got.frame_done);
			return;
		end
		want = pending_columns.pop_front();
		checked++;
		if (got !== want) begin
			failures++;
			if (failures <= 10) begin
				$display("column %0d mismatch", checked);
				$display("  expected top %0d bottom %0d colour %h near %0d/%0d done %0d",
					want.top_row, want.bottom_row, want.wall_colour, want.nearest_ray,
					want.nearest_top_row, want.frame_done);
				$display("  actual   top %0d bottom %0d colour %h near %0d/%0d done %0d",
					got.top_row, got.bottom_row, got.wall_colour, got.nearest_ray,
					got.nearest_top_row, got.frame_done);
			end
		end
	endfunction

	function int pending();
		return pending_columns.size();
	endfunction
endclass

module raycast_wall_column_projector_core_tb;
	import rcwp_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_RAYS  = 1030;
	// Indexes past the last register; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [DIST_W-1:0]    wall_distance;
	logic                 last_ray;
	logic                 out_valid;
	logic                 out_stall;
	logic [ROWS_W-1:0]    top_row;
	logic [ROWS_W-1:0]    bottom_row;
	logic [COLOUR_W-1:0]  wall_colour;
	logic [RAY_W-1:0]     nearest_ray;
	logic [ROWS_W-1:0]    nearest_top_row;
	logic                 frame_done;

	column_scoreboard  board;
	bit                no_idle = 1'b0;
	int                idle_cycles = 0;
	int                settings_used = 0;
	logic [DIST_W-1:0] last_distance = '0;

	raycast_wall_column_projector_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.wall_distance(wall_distance),
		.last_ray(last_ray),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.top_row(top_row),
		.bottom_row(bottom_row),
		.wall_colour(wall_colour),
		.nearest_ray(nearest_ray),
		.nearest_top_row(nearest_top_row),
		.frame_done(frame_done)
	);

	// 100 MHz clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: ends the run if no channel moves anything for too long.
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)
				|| (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: stalls a random number of cycles, then takes one column.
	initial begin : result_sink
		int             hold;
		column_result_t got;
		out_stall = 1'b0;
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 4);
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			got.top_row = top_row;
			got.bottom_row = bottom_row;
			got.wall_colour = wall_colour;
			got.nearest_ray = nearest_ray;
			got.nearest_top_row = nearest_top_row;
			got.frame_done = frame_done;
			board.check_result(got);
		end
	end

	// One register write on the configuration channel.
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		board.set_register(index, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One ray request after a random gap; returns once the block has taken it.
	task automatic send_ray(input logic [DIST_W-1:0] distance, input logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			wall_distance <= 16'($urandom);
			last_ray <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		wall_distance <= distance;
		last_ray <= last;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		board.note_request(distance, last);
		last_distance = distance;
	endtask

	// Lowers the request and waits until every column has been delivered.
	task automatic drain_columns();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Loads a full register setting while the block is idle.
	task automatic load_setting(input logic [31:0] rows, input logic [31:0] scale,
			input logic [31:0] c0, input logic [31:0] c1, input logic [31:0] c2,
			input logic [31:0] c3);
		drain_columns();
		write_register(REG_SCREEN_ROWS, rows);
		write_register(REG_WALL_SCALE, scale);
		write_register(REG_SHADE_0, c0);
		write_register(REG_SHADE_1, c1);
		write_register(REG_SHADE_2, c2);
		write_register(REG_SHADE_3, c3);
		if ($urandom_range(0, 2) == 0)
			write_register($urandom_range(0, 1) ? REG_SPARE_7 : REG_SPARE_6, $urandom);
		settings_used++;
	endtask

	// Random distance: mostly full range, with zero, maximum, near range, band edges and ties.
	function automatic logic [DIST_W-1:0] draw_distance();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return '0;
			1: return '1;
			2: return 16'($urandom_range(1, 255));
			3: return 16'($urandom_range(1, 3) * 768 - 1 + $urandom_range(0, 1));
			4: return last_distance;
			default: return 16'($urandom);
		endcase
	endfunction

	// Main sequence: reset, directed rays, then random phases.
	initial begin : stimulus
		int          total;
		int          phase;
		int          count;
		int          phase_items;
		int          frame_len;
		logic        last;
		logic [31:0] rows_word;
		logic [31:0] scale_word;
		board = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		wall_distance = '0;
		last_ray = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings first.
		send_ray(16'h0400, 1'b0);
		send_ray(16'hFFFF, 1'b0);

		// One frame across all bands, with ties at equal and at zero distance.
		load_setting(32'd480, 32'(SCALE_RESET), 32'h00FF0000, 32'h0000FF00, 32'h000000FF,
			32'hFFFFFFFF);
		send_ray(16'h8000, 1'b0);
		send_ray(16'h0400, 1'b0);
		send_ray(16'h0400, 1'b0);
		send_ray(16'h0000, 1'b0);
		send_ray(16'h0000, 1'b0);
		send_ray(16'h0001, 1'b0);
		send_ray(16'd767, 1'b0);
		send_ray(16'd768, 1'b0);
		send_ray(16'd1535, 1'b0);
		send_ray(16'd1536, 1'b0);
		send_ray(16'd2303, 1'b0);
		send_ray(16'd2304, 1'b0);
		send_ray(16'hFFFF, 1'b0);
		send_ray(16'h0200, 1'b1);
		// A frame of one ray at the farthest distance is still its own closest ray.
		send_ray(16'hFFFF, 1'b1);

		// Odd row count with the largest scale.
		load_setting(32'd1023, 32'h00FFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0, 32'hA5A5A5A5);
		send_ray(16'hFFFF, 1'b0);
		send_ray(16'h4000, 1'b1);

		// Smallest screen with zero scale.
		load_setting(32'd2, 32'd0, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0);
		send_ray(16'h0001, 1'b0);
		send_ray(16'h0000, 1'b1);

		// Random phases, each with its own setting.
		total = 0;
		phase = 0;
		while (total < RANDOM_RAYS) begin
			case (phase)
				0: begin
					rows_word = 32'd1022;
					scale_word = 32'h00FFFFFF;
				end
				1: begin
					rows_word = 32'd2;
					scale_word = 32'($urandom_range(0, 3));
				end
				default: begin
					if ($urandom_range(0, 3) == 0)
						rows_word = $urandom;
					else
						rows_word = ($urandom & ~32'h3FF) | 32'($urandom_range(1, 511) * 2);
					scale_word = $urandom >> $urandom_range(8, 31);
					scale_word[31:24] = 8'($urandom);
				end
			endcase
			load_setting(rows_word, scale_word, $urandom, $urandom, $urandom, $urandom);
			no_idle = ($urandom_range(0, 3) == 0);
			phase_items = $urandom_range(60, 140);
			count = 0;
			while (count < phase_items && total < RANDOM_RAYS) begin
				// Mostly short frames; now and then one longer than the ray count.
				if ($urandom_range(0, 14) == 0 || (phase == 2 && count == 0))
					frame_len = $urandom_range(129, 150);
				else
					frame_len = $urandom_range(1, 24);
				for (int r = 0; r < frame_len && total < RANDOM_RAYS; r++) begin
					// An occasional frame loses its last-ray mark and runs into the next.
					last = (r == frame_len - 1) && ($urandom_range(0, 9) != 0);
					send_ray(draw_distance(), last);
					count++;
					total++;
				end
			end
			phase++;
		end

		drain_columns();
		no_idle = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d columns in %0d frames over %0d register settings",
			board.checked, board.frames, settings_used);
		$display("mismatching or unexpected columns: %0d", board.failures);
		if (board.failures == 0 && board.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
